/* rtl/mbf_pkg.sv */
// Shared types, constants and the chip lookup for the Manchester byte framer.
// No dependencies; imported by every rtl module of the framer.
package mbf_pkg;

    localparam logic [7:0] NEWLINE_CODE = 8'h0A;
    localparam logic [7:0] CR_CODE      = 8'h0D;

    localparam int unsigned SYNC_LEN   = 5;
    localparam int unsigned FRAME_LEN  = 21;
    localparam int unsigned CHIP_IDX_W = 5;

    // chip i of the sync pattern is bit i: silent, burst, burst, burst, silent
    localparam logic [SYNC_LEN-1:0] SYNC_PATTERN = 5'b01110;

    localparam logic [CHIP_IDX_W-1:0] LAST_IDX = CHIP_IDX_W'(FRAME_LEN - 1);

    localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

    // one classified word between front and back
    typedef struct packed {
        logic [7:0] data;      // byte to frame
        logic       cr_first;  // send a carriage-return frame ahead of it
    } mbf_cmd_t;

    // chip value at position idx of the frame for byte b
    function automatic logic chip_at(input logic [7:0] b, input logic [CHIP_IDX_W-1:0] idx);
        logic [CHIP_IDX_W-1:0] k;
        logic [2:0]            bit_sel;
        logic                  result;
        begin
            k       = idx - CHIP_IDX_W'(SYNC_LEN);
            bit_sel = 3'd7 - k[3:1];
            if (idx < CHIP_IDX_W'(SYNC_LEN)) begin
                result = SYNC_PATTERN[idx[2:0]];
            end else begin
                result = b[bit_sel] ^ k[0];
            end
            return result;
        end
    endfunction

endpackage

/* rtl/mbf_front.sv */
// Front end: holds the newline-expansion register and classifies each byte.
// Depends on mbf_pkg.
module mbf_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic             cfg_data,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [7:0]       s_data_byte,
    input  logic             queue_full,
    output logic             push,
    output mbf_pkg::mbf_cmd_t push_cmd
);
    import mbf_pkg::*;

    logic crlf_enable_reg;
    logic crlf_enable_next;

    assign cfg_ready = 1'b1;

    always_comb begin
        crlf_enable_next = crlf_enable_reg;
        if (cfg_valid) begin
            crlf_enable_next = cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crlf_enable_reg <= 1'b1;
        end else begin
            crlf_enable_reg <= crlf_enable_next;
        end
    end

    assign s_ready           = !queue_full;
    assign push              = s_valid && !queue_full;
    assign push_cmd.data     = s_data_byte;
    assign push_cmd.cr_first = crlf_enable_reg && (s_data_byte == NEWLINE_CODE);

endmodule

/* rtl/mbf_queue.sv */
// Short command queue between the front end and the serializer.
// Depends on mbf_pkg.
module mbf_queue #(
    parameter int unsigned DEPTH = mbf_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  mbf_pkg::mbf_cmd_t push_cmd,
    output logic              full,
    input  logic              pop,
    output logic              not_empty,
    output mbf_pkg::mbf_cmd_t head_cmd
);
    import mbf_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    mbf_cmd_t          entries [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg,  count_next;

    assign full      = (count_reg == CNT_FULL);
    assign not_empty = (count_reg != '0);
    assign head_cmd  = entries[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

/* rtl/mbf_back.sv */
// Back end: serializes queued commands into chips, one per cycle while m_ready accepts, into an
// output register. Depends on mbf_pkg.
module mbf_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cmd_valid,
    input  mbf_pkg::mbf_cmd_t cmd,
    output logic              pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_chip,
    output logic              m_last_chip
);
    import mbf_pkg::*;

    logic                  busy_reg,       busy_next;
    logic                  cr_pending_reg, cr_pending_next;
    logic [7:0]            byte_reg,       byte_next;
    logic [CHIP_IDX_W-1:0] idx_reg,        idx_next;
    logic                  m_valid_reg,    m_valid_next;
    logic                  m_chip_reg,     m_chip_next;
    logic                  m_last_reg,     m_last_next;

    logic       out_free;
    logic       advance;
    logic       frame_end;
    logic       word_end;
    logic [7:0] cur_byte;

    assign out_free  = !m_valid_reg || m_ready;
    assign advance   = busy_reg && out_free;
    assign frame_end = (idx_reg == LAST_IDX);
    assign word_end  = frame_end && !cr_pending_reg;
    assign cur_byte  = cr_pending_reg ? CR_CODE : byte_reg;
    assign pop       = cmd_valid && (!busy_reg || (advance && word_end));

    always_comb begin
        busy_next       = busy_reg;
        cr_pending_next = cr_pending_reg;
        byte_next       = byte_reg;
        idx_next        = idx_reg;
        m_valid_next    = m_valid_reg;
        m_chip_next     = m_chip_reg;
        m_last_next     = m_last_reg;

        if (advance) begin
            m_valid_next = 1'b1;
            m_chip_next  = chip_at(cur_byte, idx_reg);
            m_last_next  = word_end;
            if (frame_end) begin
                idx_next        = '0;
                cr_pending_next = 1'b0;
                if (!cr_pending_reg) begin
                    busy_next = 1'b0;
                end
            end else begin
                idx_next = idx_reg + 1'b1;
            end
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end

        if (pop) begin
            busy_next       = 1'b1;
            byte_next       = cmd.data;
            cr_pending_next = cmd.cr_first;
            idx_next        = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg       <= 1'b0;
            cr_pending_reg <= 1'b0;
            idx_reg        <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            busy_reg       <= busy_next;
            cr_pending_reg <= cr_pending_next;
            idx_reg        <= idx_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg   <= byte_next;
        m_chip_reg <= m_chip_next;
        m_last_reg <= m_last_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_chip      = m_chip_reg;
    assign m_last_chip = m_last_reg;

endmodule

/* rtl/manchester_byte_framer.sv */
// Manchester byte framer: one byte in, a 21-chip frame out (42 for an expanded newline).
// Path: a byte's first chip passes the queue, the serializer load and the chip register in turn.
// Throughput: one chip per cycle while m_ready accepts, 21 chips per byte, 42 for an expanded newline;
// the serializer in the back end sets that rate, the queue lets input run ahead.
// Reset: synchronous active-low aresetn empties queue and output, sets crlf_enable to 1.
module manchester_byte_framer #(
    parameter int unsigned QUEUE_DEPTH = mbf_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic       aclk,
    input  logic       aresetn,

    // configuration: bit 0 is crlf_enable
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data,

    // byte input
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,

    // chip output
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_chip,
    output logic       m_last_chip
);
    import mbf_pkg::*;

    // front -> queue
    logic     push;
    mbf_cmd_t push_cmd;
    logic     queue_full;

    // queue -> back
    logic     pop;
    logic     queue_not_empty;
    mbf_cmd_t head_cmd;

    // Front end: config register, newline classification. A newline with
    // expansion on becomes a single word tagged cr_first; the back end
    // sends the CR frame and then the newline frame from it.
    mbf_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .queue_full  (queue_full),
        .push        (push),
        .push_cmd    (push_cmd)
    );

    // Short queue decouples byte acceptance from chip serialization.
    mbf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (queue_not_empty),
        .head_cmd  (head_cmd)
    );

    // Back end: chip counter walks sync then data chips; the next word is
    // loaded on the last chip of the current one, so frames run gap-free.
    mbf_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd_valid   (queue_not_empty),
        .cmd         (head_cmd),
        .pop         (pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_chip      (m_chip),
        .m_last_chip (m_last_chip)
    );

endmodule
